// ===== hdl/ljmed_pkg.sv =====
// Shared constants for the Lennard-Jones move energy delta unit.
// Field widths, command and register codes, reset values, output limits.
// No dependencies.
`default_nettype none
package ljmed_pkg;

  localparam int MAX_ATOMS_DEF = 64;

  localparam int POS_W = 32;
  localparam int IDX_W = 6;
  localparam int CFG_W = 32;
  localparam int CNT_W = 7;
  localparam int OUT_W = 48;

  // Input kinds carried on in_tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_CUTOFF = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  localparam logic [CFG_W-1:0] CUTOFF_RST = 32'd589824;
  localparam logic [CNT_W-1:0] COUNT_RST  = 7'd64;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 48'sh8000_0000_0000;

endpackage
`default_nettype wire

// ===== hdl/lj_move_energy_delta_unit.sv =====
// Lennard-Jones move energy delta unit: position memory and pair sequencer.
// Depends on ljmed_pkg.
`default_nettype none
// Keeps up to MAX_ATOMS atom positions (signed Q16.16 per axis) in one
// synchronous memory. A write item (in_tuser = 0) stores a position and
// gives no result. An evaluate item (in_tuser = 1) sums the truncated 12-6
// pair term against every other active atom for the proposed and for the
// stored position and returns new minus old in signed Q24.24, saturated,
// with out_tuser set when any term or the sum saturated. For a pair inside
// the cutoff, the 28-step restoring divider forms 1/r^2; a pair outside the
// cutoff or too close skips it. The input is taken again while a finished
// result still waits on the output register.
module lj_move_energy_delta_unit #(
  parameter int MAX_ATOMS = ljmed_pkg::MAX_ATOMS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [5:0] atom_index, [37:6] pos_x, [69:38] pos_y, [101:70] pos_z, rest zero
  input  wire logic [103:0] in_tdata,
  // [0] cmd
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [47:0] energy_change
  output logic [47:0]       out_tdata,
  // [0] saturated
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int AW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int NW   = $clog2(MAX_ATOMS + 1);
  localparam int ACCW = ljmed_pkg::OUT_W + AW + 2;
  localparam int PW   = ljmed_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_OLD, S_NEXT, S_PWAIT, S_DIFF, S_SQ, S_SUM, S_DIV,
    S_S2, S_S3, S_S6A, S_S6B, S_TERM, S_ACC, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [31:0] cutoff_r;
  logic [6:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= ljmed_pkg::CUTOFF_RST;
      count_r  <= ljmed_pkg::COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ljmed_pkg::CFG_CUTOFF: cutoff_r <= cfg_data;
        ljmed_pkg::CFG_COUNT:  count_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // input unpacking
  logic [5:0]    in_idx;
  logic [PW-1:0] in_x, in_y, in_z;
  logic          in_acc, idx_ok;
  assign in_idx    = in_tdata[5:0];
  assign in_x      = in_tdata[37:6];
  assign in_y      = in_tdata[69:38];
  assign in_z      = in_tdata[101:70];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign idx_ok    = (32'(in_idx) < 32'(MAX_ATOMS));

  // position memory, x/y/z side by side
  logic [3*PW-1:0] mem [MAX_ATOMS];
  logic [3*PW-1:0] rd_data_r;
  logic            mem_we, rd_en;
  logic [AW-1:0]   rd_addr;
  logic [NW-1:0]   i_r, n_r;
  logic [AW-1:0]   idx_r;

  assign mem_we = in_acc && (in_tuser[0] == ljmed_pkg::CMD_WRITE) && idx_ok;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(in_idx);
    if (state_r == S_IDLE) begin
      rd_en = in_acc && (in_tuser[0] == ljmed_pkg::CMD_EVAL);
    end else if (state_r == S_NEXT) begin
      rd_en   = (i_r < n_r) && (i_r[AW-1:0] != idx_r);
      rd_addr = i_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(in_idx)] <= {in_z, in_y, in_x};
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // datapath registers
  logic [PW-1:0] nx_r, ny_r, nz_r, ox_r, oy_r, oz_r, px_r, py_r, pz_r;
  logic          pass_r, flag_r;
  logic [31:0]   mx_r, my_r, mz_r;
  logic [63:0]   qx_r, qy_r, qz_r;
  logic [49:0]   r_r, rem_r;
  logic [27:0]   s_r;
  logic [4:0]    dcnt_r;
  logic [31:0]   s2_r;
  logic [35:0]   s3_r, plo_r;
  logic [47:0]   s6_r;
  logic signed [47:0]   term_r;
  logic signed [ACCW-1:0] acc_r;
  logic [47:0]   out_data_r;
  logic          out_flag_r, out_valid_r;

  // pair operand selection and differences
  logic [PW-1:0] ax, ay, az;
  logic signed [PW:0] dx, dy, dz;
  assign ax = pass_r ? ox_r : nx_r;
  assign ay = pass_r ? oy_r : ny_r;
  assign az = pass_r ? oz_r : nz_r;
  assign dx = $signed({ax[PW-1], ax}) - $signed({px_r[PW-1], px_r});
  assign dy = $signed({ay[PW-1], ay}) - $signed({py_r[PW-1], py_r});
  assign dz = $signed({az[PW-1], az}) - $signed({pz_r[PW-1], pz_r});

  // cutoff checks and squared distance
  logic [63:0] lim;
  logic [49:0] r_sum;
  logic        far;
  assign lim   = {16'd0, cutoff_r, 16'd0};
  assign r_sum = {2'b0, qx_r[47:0]} + {2'b0, qy_r[47:0]} + {2'b0, qz_r[47:0]};
  assign far   = (qx_r >= lim) || (qy_r >= lim) || (qz_r >= lim)
              || ({14'd0, r_sum} >= lim);

  // divider step
  logic [50:0] rem2;
  logic        dfit;
  assign rem2 = {rem_r, 1'b0};
  assign dfit = (rem2 >= {1'b0, r_r});

  // products
  logic [55:0] p_s2;
  logic [59:0] p_s3, p_lo;
  logic [47:0] p_hi;
  assign p_s2 = 56'(s_r) * 56'(s_r);
  assign p_s3 = 60'(s2_r) * 60'(s_r);
  assign p_lo = 60'(s3_r[23:0]) * 60'(s3_r);
  assign p_hi = 48'(s3_r[35:24]) * 48'(s3_r);

  // term formation
  logic [49:0] t_pos;
  logic [37:0] t_neg;
  assign t_pos = (50'(s6_r) - 50'(s3_r)) << 2;
  assign t_neg = {2'b0, (s3_r - s6_r[35:0])} << 2;

  // final saturation
  logic acc_hi, acc_lo;
  assign acc_hi = !acc_r[ACCW-1] && (acc_r[ACCW-2:47] != '0);
  assign acc_lo = acc_r[ACCW-1] && (acc_r[ACCW-2:47] != '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
      flag_r      <= 1'b0;
      i_r         <= '0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_FIN)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_tuser[0] == ljmed_pkg::CMD_EVAL)) begin
            nx_r   <= in_x;
            ny_r   <= in_y;
            nz_r   <= in_z;
            idx_r  <= AW'(in_idx);
            acc_r  <= '0;
            flag_r <= 1'b0;
            i_r    <= '0;
            n_r    <= (32'(count_r) > 32'(MAX_ATOMS)) ? NW'(MAX_ATOMS) : NW'(count_r);
            state_r <= idx_ok ? S_OLD : S_FIN;
          end
        end
        S_OLD: begin
          ox_r    <= rd_data_r[PW-1:0];
          oy_r    <= rd_data_r[2*PW-1:PW];
          oz_r    <= rd_data_r[3*PW-1:2*PW];
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (i_r >= n_r) begin
            state_r <= S_FIN;
          end else if (i_r[AW-1:0] == idx_r) begin
            i_r <= i_r + NW'(1);
          end else begin
            state_r <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          px_r    <= rd_data_r[PW-1:0];
          py_r    <= rd_data_r[2*PW-1:PW];
          pz_r    <= rd_data_r[3*PW-1:2*PW];
          pass_r  <= 1'b0;
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          mx_r    <= dx[PW] ? 32'(-dx) : 32'(dx);
          my_r    <= dy[PW] ? 32'(-dy) : 32'(dy);
          mz_r    <= dz[PW] ? 32'(-dz) : 32'(dz);
          state_r <= S_SQ;
        end
        S_SQ: begin
          qx_r    <= 64'(mx_r) * 64'(mx_r);
          qy_r    <= 64'(my_r) * 64'(my_r);
          qz_r    <= 64'(mz_r) * 64'(mz_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          r_r <= r_sum;
          if (far) begin
            term_r  <= '0;
            state_r <= S_ACC;
          end else if (r_sum <= (50'd1 << 28)) begin
            // coincident or too close: 1/r^2 at or above 16.0
            term_r  <= ljmed_pkg::OUT_MAX;
            flag_r  <= 1'b1;
            state_r <= S_ACC;
          end else begin
            rem_r   <= 50'd1 << 28;
            s_r     <= '0;
            dcnt_r  <= 5'd27;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= dfit ? 50'(rem2 - {1'b0, r_r}) : rem2[49:0];
          s_r   <= {s_r[26:0], dfit};
          if (dcnt_r == '0) state_r <= S_S2;
          else dcnt_r <= dcnt_r - 5'd1;
        end
        S_S2: begin
          s2_r    <= p_s2[55:24];
          state_r <= S_S3;
        end
        S_S3: begin
          s3_r    <= p_s3[59:24];
          state_r <= S_S6A;
        end
        S_S6A: begin
          plo_r   <= p_lo[59:24];
          state_r <= S_S6B;
        end
        S_S6B: begin
          s6_r    <= p_hi + 48'(plo_r);
          state_r <= S_TERM;
        end
        S_TERM: begin
          if (s6_r >= 48'(s3_r)) begin
            if (t_pos > 50'(ljmed_pkg::OUT_MAX)) begin
              term_r <= ljmed_pkg::OUT_MAX;
              flag_r <= 1'b1;
            end else begin
              term_r <= $signed(t_pos[47:0]);
            end
          end else begin
            term_r <= -$signed(48'(t_neg));
          end
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (!pass_r) begin
            acc_r   <= acc_r + ACCW'(term_r);
            pass_r  <= 1'b1;
            state_r <= S_DIFF;
          end else begin
            acc_r   <= acc_r - ACCW'(term_r);
            i_r     <= i_r + NW'(1);
            state_r <= S_NEXT;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            if (acc_hi) begin
              out_data_r <= ljmed_pkg::OUT_MAX;
            end else if (acc_lo) begin
              out_data_r <= ljmed_pkg::OUT_MIN;
            end else begin
              out_data_r <= acc_r[47:0];
            end
            out_flag_r  <= flag_r || acc_hi || acc_lo;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_flag_r;

  // a write item never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser[0] == ljmed_pkg::CMD_WRITE) && !out_tvalid) |=> !out_tvalid)
    else $error("write item produced a result");

  // an evaluate item blocks the input until its result is formed
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser[0] == ljmed_pkg::CMD_EVAL)) |=> !in_tready)
    else $error("input accepted during evaluate");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < r_r))
    else $error("divider remainder out of range");

  // partner counter never passes the active count
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PWAIT) |-> (i_r < n_r))
    else $error("partner index beyond active count");

endmodule
`default_nettype wire

// ===== test/lj_move_energy_delta_unit_test.sv =====
// Self-checking testbench for lj_move_energy_delta_unit: writes atom positions,
// evaluates moves under several cutoff/count settings, checks against an inline model.
// Depends on ljmed_pkg and the unit RTL.
`timescale 1ns / 100ps
module lj_move_energy_delta_unit_test;

  typedef struct {
    logic             cmd;
    logic [5:0]       idx;
    logic [31:0]      px, py, pz;
  } move_item_t;

  localparam int IDLE_LIMIT = 40000;
  localparam longint E_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint E_MIN = -E_MAX - 1;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  lj_move_energy_delta_unit DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  logic [31:0] mdl_cutoff = ljmed_pkg::CUTOFF_RST;
  logic [6:0]  mdl_count = ljmed_pkg::COUNT_RST;
  logic [31:0] mdl_x [64], mdl_y [64], mdl_z [64];
  // generator-side copy of the positions, used to make coincident moves
  logic [31:0] gen_x [64], gen_y [64], gen_z [64];

  move_item_t  pend_q [$];
  logic [47:0] exp_energy_q [$];
  logic        exp_sat_q [$];
  int          fails = 0;
  int          queued = 0;
  int          in_acc = 0, in_seen = 0, out_acc = 0, out_seen = 0;
  int          in_gap = 0, out_stall = 0, idle_cycles = 0;

  function automatic longint unsigned mul_q24(longint unsigned a, longint unsigned b);
    return (a >> 24) * b + (((a & 64'hFF_FFFF) * b) >> 24);
  endfunction

  // one truncated 12-6 pair term in Q24.24
  function automatic longint lj_term(longint ax, longint ay, longint az,
                                     longint bx, longint by, longint bz,
                                     inout bit sat);
    longint unsigned lim, qx, qy, qz, r, s, s2, s3, s6, t;
    longint d;
    lim = longint'(mdl_cutoff) << 16;
    d = ax - bx; if (d < 0) d = -d; qx = d * d;
    d = ay - by; if (d < 0) d = -d; qy = d * d;
    d = az - bz; if (d < 0) d = -d; qz = d * d;
    if (qx >= lim || qy >= lim || qz >= lim) return 0;
    r = qx + qy + qz;
    if (r >= lim) return 0;
    if (r == 0) begin
      sat = 1'b1;
      return E_MAX;
    end
    s = (64'd1 << 56) / r;
    if (s >= (64'd16 << 24)) begin
      sat = 1'b1;
      return E_MAX;
    end
    s2 = (s * s) >> 24;
    s3 = (s2 * s) >> 24;
    s6 = mul_q24(s3, s3);
    if (s6 >= s3) begin
      t = (s6 - s3) * 4;
      if (t > E_MAX) begin
        sat = 1'b1;
        return E_MAX;
      end
      return longint'(t);
    end
    return -longint'((s3 - s6) * 4);
  endfunction

  // update model for one accepted item, queue the expected result of an evaluate
  task automatic predict_move(input logic cmd, input logic [5:0] idx,
                              input logic [31:0] nx, ny, nz);
    longint acc;
    bit     sat;
    int     n;
    if (cmd == ljmed_pkg::CMD_WRITE) begin
      mdl_x[idx] = nx; mdl_y[idx] = ny; mdl_z[idx] = nz;
    end else begin
      acc = 0; sat = 1'b0;
      n = (int'(mdl_count) > 64) ? 64 : int'(mdl_count);
      for (int i = 0; i < n; i++) begin
        if (i != idx) begin
          acc += lj_term($signed(nx), $signed(ny), $signed(nz),
                         $signed(mdl_x[i]), $signed(mdl_y[i]), $signed(mdl_z[i]), sat);
          acc -= lj_term($signed(mdl_x[idx]), $signed(mdl_y[idx]), $signed(mdl_z[idx]),
                         $signed(mdl_x[i]), $signed(mdl_y[i]), $signed(mdl_z[i]), sat);
        end
      end
      if (acc > E_MAX) begin acc = E_MAX; sat = 1'b1; end
      if (acc < E_MIN) begin acc = E_MIN; sat = 1'b1; end
      exp_energy_q.push_back(acc[47:0]);
      exp_sat_q.push_back(sat);
    end
  endtask

  // input side: accept tracking, prediction, result check, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_tvalid && in_tready) begin
        predict_move(in_tuser[0], in_tdata[5:0], in_tdata[37:6], in_tdata[69:38],
                     in_tdata[101:70]);
        in_acc++;
        idle_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        out_acc++;
        idle_cycles = 0;
        if (exp_energy_q.size() == 0) begin
          $error("unexpected result: energy_change %h saturated %b", out_tdata, out_tuser);
          fails++;
        end else begin
          if (out_tdata !== exp_energy_q[0]) begin
            $error("energy_change expected %h actual %h", exp_energy_q[0], out_tdata);
            fails++;
          end
          if (out_tuser[0] !== exp_sat_q[0]) begin
            $error("saturated expected %b actual %b", exp_sat_q[0], out_tuser[0]);
            fails++;
          end
          void'(exp_energy_q.pop_front());
          void'(exp_sat_q.pop_front());
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("lj_move_energy_delta_unit verification failed");
        $finish;
      end
    end
  end

  function automatic int draw_wait();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // driver: present queued items with random gaps
  always @(negedge clk) begin
    move_item_t it;
    logic load;
    if (rst_n) begin
      load = 1'b0;
      if (in_tvalid) begin
        if (in_seen != in_acc) begin
          in_seen = in_acc;
          in_gap = draw_wait();
          load = (in_gap == 0 && pend_q.size() > 0);
          if (!load) in_tvalid <= 1'b0;
        end
      end else if (in_gap > 0) begin
        in_gap--;
      end else if (pend_q.size() > 0) begin
        load = 1'b1;
      end
      if (load) begin
        it = pend_q.pop_front();
        in_tdata <= {2'b00, it.pz, it.py, it.px, it.idx};
        in_tuser <= it.cmd;
        in_tvalid <= 1'b1;
      end
    end
  end

  // sink: random stalls per result
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_seen != out_acc) begin
        out_seen = out_acc;
        out_stall = draw_wait();
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_item(input logic cmd, input logic [5:0] idx,
                            input logic [31:0] x, y, z);
    move_item_t it;
    it.cmd = cmd; it.idx = idx; it.px = x; it.py = y; it.pz = z;
    pend_q.push_back(it);
    queued++;
    if (cmd == ljmed_pkg::CMD_WRITE) begin
      gen_x[idx] = x; gen_y[idx] = y; gen_z[idx] = z;
    end
  endtask

  // coordinate in a box of +/-4.0 so that many pairs fall inside the cutoff
  function automatic logic [31:0] near_coord();
    return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
  endfunction

  // every queued item accepted and every result checked
  task automatic wait_quiet();
    wait (in_acc == queued && exp_energy_q.size() == 0);
    repeat (32) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    if (idx == ljmed_pkg::CFG_CUTOFF) mdl_cutoff = val;
    else mdl_count = val[6:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_moves(input int num);
    int   c, k;
    logic [5:0] idx;
    for (int n = 0; n < num; n++) begin
      c = (int'(mdl_count) > 64) ? 64 : int'(mdl_count);
      idx = (c > 0 && $urandom_range(0, 7) != 0) ? 6'($urandom_range(0, c - 1))
                                                : 6'($urandom_range(0, 63));
      k = $urandom_range(0, 9);
      if (k == 0)        // move onto another atom
        queue_item(ljmed_pkg::CMD_EVAL, idx, gen_x[idx ^ 6'd1], gen_y[idx ^ 6'd1],
                   gen_z[idx ^ 6'd1]);
      else if (k == 1)   // any coordinates at all
        queue_item(1'($urandom_range(0, 1)), idx, $urandom, $urandom, $urandom);
      else
        queue_item(1'($urandom_range(0, 1)), idx, near_coord(), near_coord(), near_coord());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the whole store on a loose lattice, spacing 1.25
    for (int i = 0; i < 64; i++)
      queue_item(ljmed_pkg::CMD_WRITE, 6'(i), (i % 4) * 32'h1_4000,
                 ((i / 4) % 4) * 32'h1_4000, (i / 16) * 32'h1_4000);
    // directed: extremes, coincident and close atoms, edge indexes
    queue_item(ljmed_pkg::CMD_EVAL, 6'd0, 32'h0001_4000, 32'h0, 32'h0);
    queue_item(ljmed_pkg::CMD_EVAL, 6'd63, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_item(ljmed_pkg::CMD_EVAL, 6'd5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_item(ljmed_pkg::CMD_EVAL, 6'd0, 32'h0000_1000, 32'h0, 32'h0);
    queue_item(ljmed_pkg::CMD_EVAL, 6'd21, 32'h0001_A000, 32'h0001_A000, 32'h0001_A000);
    queue_item(ljmed_pkg::CMD_WRITE, 6'd62, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_item(ljmed_pkg::CMD_EVAL, 6'd62, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_item(ljmed_pkg::CMD_WRITE, 6'd62, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
    queue_item(ljmed_pkg::CMD_EVAL, 6'd63, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    random_moves(40);
    wait_quiet();

    // several settings, extremes among them
    write_reg(ljmed_pkg::CFG_CUTOFF, 32'hFFFF_FFFF); write_reg(ljmed_pkg::CFG_COUNT, 32'd2);
    random_moves(90);
    wait_quiet();
    write_reg(ljmed_pkg::CFG_CUTOFF, 32'h0); write_reg(ljmed_pkg::CFG_COUNT, 32'd16);
    random_moves(70);
    wait_quiet();
    write_reg(ljmed_pkg::CFG_CUTOFF, 32'h0004_0000); write_reg(ljmed_pkg::CFG_COUNT, 32'd8);
    random_moves(90);
    wait_quiet();
    write_reg(ljmed_pkg::CFG_COUNT, 32'd0);
    random_moves(30);
    wait_quiet();
    write_reg(ljmed_pkg::CFG_COUNT, 32'd1);
    random_moves(30);
    wait_quiet();
    write_reg(ljmed_pkg::CFG_CUTOFF, 32'h0001_0000); write_reg(ljmed_pkg::CFG_COUNT, 32'd127);
    random_moves(50);
    wait_quiet();
    write_reg(ljmed_pkg::CFG_CUTOFF, 32'hFFFF_FFFF); write_reg(ljmed_pkg::CFG_COUNT, 32'd64);
    random_moves(30);
    wait_quiet();
    write_reg(ljmed_pkg::CFG_CUTOFF, ljmed_pkg::CUTOFF_RST);
    write_reg(ljmed_pkg::CFG_COUNT, 32'd12);
    random_moves(110);
    wait_quiet();
    write_reg(ljmed_pkg::CFG_CUTOFF, 32'h0010_0000); write_reg(ljmed_pkg::CFG_COUNT, 32'd4);
    random_moves(90);

    wait (in_acc == queued && exp_energy_q.size() == 0);
    repeat (100) @(posedge clk);
    if (fails == 0)
      $display("lj_move_energy_delta_unit verification clean");
    else
      $display("lj_move_energy_delta_unit verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ljmed_pkg.sv
hdl/lj_move_energy_delta_unit.sv
test/lj_move_energy_delta_unit_test.sv
